>>> design/kem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kem_pkg;

    // Store geometry.
    localparam int DEPTH      = 24;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths.
    localparam int KEY_W      = 8;
    localparam int MOD_W      = 8;
    localparam int CONS_W     = 6;
    localparam int NOW_W      = 32;
    localparam int STAMP_BITS = 32;
    localparam int EXPIRE_W   = 16;
    localparam int ENTRY_W    = KEY_W + STAMP_BITS;

    localparam logic [EXPIRE_W-1:0] EXPIRE_RESET = 16'd750;

    // Modifier bits that mark a control or alt chord.
    localparam logic [MOD_W-1:0] REJECT_MODS = 8'h0e;

    // Operation codes.
    localparam logic OP_KEY     = 1'b0;
    localparam logic OP_DISPLAY = 1'b1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_EXPIRE = 1'b0;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed
    {
        logic                operation;
        logic [KEY_W-1:0]    character;
        logic                is_keysym;
        logic                key_down;
        logic [MOD_W-1:0]    modifiers;
        logic [CONS_W-1:0]   console_id;
        logic [NOW_W-1:0]    now;
    } item_t;

    typedef struct packed
    {
        logic             is_echo;
        logic             key_stored;
        logic [CNT_W-1:0] pending_count;
    } res_t;

    // Circular pointer step.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // Circular pointer plus an offset of at most DEPTH.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        logic [CNT_W:0] w;
        s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
        if (s >= (CNT_W + 1)'(DEPTH))
            w = s - (CNT_W + 1)'(DEPTH);
        else
            w = s;
        return w[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/kem_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with a registered read.
module kem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/kem_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Keystroke store held as a ring in one RAM, with a sequential echo search.
module kem_engine
    import kem_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire item_t               item,
    input  wire logic [EXPIRE_W-1:0] expire_ticks,
    input  wire logic                out_busy,
    output logic                     res_valid,
    output res_t                     res
);

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CONS_W-1:0] last_console_reg, last_console_next;
    logic [PTR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [KEY_W-1:0]  ch_reg, ch_next;
    logic [STAMP_BITS-1:0] now_reg, now_next;

    logic                  accept;
    logic                  key_ok;
    logic [CNT_W-1:0]      count_base;
    logic                  full;
    logic [PTR_W-1:0]      tail;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]      rd_key;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [STAMP_BITS-1:0] age;
    logic                  hit;
    logic                  last;
    logic [CNT_W-1:0]      idx_inc;

    assign item_stall = (state_reg != ST_IDLE) || out_busy;
    assign accept     = item_valid && !item_stall;

    assign key_ok = item.is_keysym && item.key_down && (item.character != '0)
                    && ((item.modifiers & REJECT_MODS) == '0);

    assign count_base = (item.console_id != last_console_reg) ? '0 : count_reg;
    assign full       = (count_base == CNT_W'(DEPTH));
    assign tail       = full ? head_reg : ptr_add(head_reg, count_base);

    assign ram_we = accept && (item.operation == OP_KEY) && key_ok;

    assign {rd_key, rd_stamp} = ram_rdata;
    assign age     = now_reg - rd_stamp;
    assign hit     = (rd_key == ch_reg) && (age <= STAMP_BITS'(expire_ticks));
    assign idx_inc = idx_reg + 1'b1;
    assign last    = (idx_inc == count_reg);

    // The read address runs one entry ahead of the compare; a write only happens
    // from the idle state, so a read never overlaps a pending write.
    assign ram_raddr = (state_reg == ST_IDLE) ? head_reg : ptr_inc(addr_reg);

    kem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail),
        .wdata ({item.character, item.now[STAMP_BITS-1:0]}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.operation == OP_DISPLAY) && (count_reg != '0))
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (hit || last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next         = head_reg;
        count_next        = count_reg;
        last_console_next = last_console_reg;
        addr_next         = addr_reg;
        idx_next          = idx_reg;
        ch_next           = ch_reg;
        now_next          = now_reg;
        res_valid         = 1'b0;
        res               = '{is_echo: 1'b0, key_stored: 1'b0, pending_count: count_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                ch_next   = item.character;
                now_next  = item.now[STAMP_BITS-1:0];
                addr_next = head_reg;
                idx_next  = '0;
                if (accept)
                begin
                    if (item.operation == OP_KEY)
                    begin
                        res_valid = 1'b1;
                        if (key_ok)
                        begin
                            last_console_next = item.console_id;
                            head_next         = full ? ptr_inc(head_reg) : head_reg;
                            count_next        = full ? count_base : count_base + 1'b1;
                            res.key_stored    = 1'b1;
                            res.pending_count = count_next;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                addr_next = ptr_inc(addr_reg);
                idx_next  = idx_inc;
                if (hit)
                begin
                    head_next         = ptr_inc(addr_reg);
                    count_next        = count_reg - idx_inc;
                    res_valid         = 1'b1;
                    res.is_echo       = 1'b1;
                    res.pending_count = count_next;
                end
                else if (last)
                begin
                    count_next        = '0;
                    res_valid         = 1'b1;
                    res.pending_count = '0;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            last_console_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            last_console_reg <= last_console_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        idx_reg  <= idx_next;
        ch_reg   <= ch_next;
        now_reg  <= now_next;
    end

endmodule

`default_nettype wire

>>> design/keystroke_echo_matcher_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Keystroke echo matcher.
// Input beats arrive on item_valid / item_stall: a keystroke event (operation 0)
// or a character shown on screen (operation 1). Every input beat yields exactly
// one result beat on result_valid / result_stall, in order, telling whether the
// character was the echo of a recent key, whether a key was stored, and how
// many keys remain pending. Keys live in a 24-entry ring held in one RAM with a
// registered read; a shown character is checked against it one entry per cycle.
// A keystroke, or a shown character with an empty store, presents its result
// in the cycle after acceptance. A shown character that examines k entries
// (1 to 24, stopping at the first unexpired match) presents its result once
// the last of them has been compared and the result registered; the first entry
// is read from the RAM in the cycle of acceptance, which hides its read latency.
// The next item is taken only once the result has been registered, so a new
// item is not taken while a search is still running.
// While a result waits in the output register, a new item is taken only in a
// cycle where that result is being taken too; otherwise item_stall is high.
// Reset (rst_n low, asynchronous) empties the store, forgets the last console
// and sets expire_ticks to 750; the RAM contents are not cleared, as no entry
// is read before it has been written. expire_ticks is written over the APB port.
module keystroke_echo_matcher_top
    import kem_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Item channel.
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic                  operation,
    input  wire logic [KEY_W-1:0]      character,
    input  wire logic                  is_keysym,
    input  wire logic                  key_down,
    input  wire logic [MOD_W-1:0]      modifiers,
    input  wire logic [CONS_W-1:0]     console_id,
    input  wire logic [NOW_W-1:0]      now,
    // Result channel.
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic                       is_echo,
    output logic                       key_stored,
    output logic [CNT_W-1:0]           pending_count,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [EXPIRE_W-1:0]  expire_reg, expire_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 out_busy;
    logic                 res_valid;
    res_t                 res;
    item_t                item;

    // Registers are decoded on the word address; the byte offset is ignored.
    assign reg_idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign expire_next = (cfg_write && (reg_idx == REG_EXPIRE))
                         ? pwdata[EXPIRE_W-1:0] : expire_reg;

    always_comb
    begin
        prdata = '0;
        if (psel && (reg_idx == REG_EXPIRE))
            prdata = APB_DATA_W'(expire_reg);
    end

    assign item = '{operation:  operation,
                    character:  character,
                    is_keysym:  is_keysym,
                    key_down:   key_down,
                    modifiers:  modifiers,
                    console_id: console_id,
                    now:        now};

    // The output register is busy when its beat is not taken in this cycle.
    assign out_busy = out_valid_reg && result_stall;

    kem_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .expire_ticks (expire_reg),
        .out_busy     (out_busy),
        .res_valid    (res_valid),
        .res          (res)
    );

    // The engine only raises res_valid when the output register is free.
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg    <= EXPIRE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expire_reg    <= expire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result_valid  = out_valid_reg;
    assign is_echo       = out_res_reg.is_echo;
    assign key_stored    = out_res_reg.key_stored;
    assign pending_count = out_res_reg.pending_count;

endmodule

`default_nettype wire

>>> tb/tb_keystroke_echo_matcher_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the keystroke echo matcher. An internal model of the
// key store predicts the result beat for every accepted input beat, and each
// result beat is compared against the oldest prediction. Input beats come in
// bursts with random gaps, and the result side stalls in several patterns.
module tb_keystroke_echo_matcher_top;

    import kem_pkg::*;

    // No beat of any kind for this many cycles means the block has hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles left after the last result so that a stray beat is still caught.
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_BEATS    = 200;

    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // Model of the key store. It sees every accepted input beat and queues the
    // result beat that the block should produce for it.
    class echo_scoreboard;
        logic [KEY_W-1:0]      keys   [DEPTH];
        logic [STAMP_BITS-1:0] stamps [DEPTH];
        int                    held;
        logic [CONS_W-1:0]     last_cons;
        logic [EXPIRE_W-1:0]   expire;
        res_t                  verdicts [$];
        int                    faults;

        function new();
            held      = 0;
            last_cons = '0;
            expire    = EXPIRE_RESET;
            faults    = 0;
        endfunction

        function void set_expire(logic [EXPIRE_W-1:0] value);
            expire = value;
        endfunction

        function bit drained();
            return verdicts.size() == 0;
        endfunction

        // Drops the n oldest keys, keeping the rest in order.
        function void shift_out(int n);
            for (int i = 0; i + n < held; i++)
            begin
                keys[i]   = keys[i + n];
                stamps[i] = stamps[i + n];
            end
            held = (n >= held) ? 0 : held - n;
        endfunction

        function void take_item(item_t it);
            res_t                  want;
            logic [STAMP_BITS-1:0] age;
            int                    hit;
            want = '0;
            if (it.operation == OP_KEY)
            begin
                if (it.is_keysym && it.key_down && it.character != '0 &&
                    (it.modifiers & REJECT_MODS) == '0)
                begin
                    if (it.console_id != last_cons)
                    begin
                        held      = 0;
                        last_cons = it.console_id;
                    end
                    if (held >= DEPTH)
                        shift_out(1);
                    keys[held]      = it.character;
                    stamps[held]    = it.now;
                    held++;
                    want.key_stored = 1'b1;
                end
            end
            else if (held != 0)
            begin
                hit = -1;
                for (int j = 0; j < held && hit < 0; j++)
                begin
                    age = it.now - stamps[j];
                    if (keys[j] == it.character && age <= STAMP_BITS'(expire))
                        hit = j;
                end
                if (hit >= 0)
                begin
                    want.is_echo = 1'b1;
                    shift_out(hit + 1);
                end
                else
                begin
                    held = 0;
                end
            end
            want.pending_count = CNT_W'(held);
            verdicts.push_back(want);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (verdicts.size() == 0)
            begin
                $error("result beat with no input beat outstanding");
                faults++;
            end
            else
            begin
                want = verdicts.pop_front();
                if (got.is_echo !== want.is_echo)
                begin
                    $error("is_echo: expected %0d, got %0d", want.is_echo, got.is_echo);
                    faults++;
                end
                if (got.key_stored !== want.key_stored)
                begin
                    $error("key_stored: expected %0d, got %0d",
                           want.key_stored, got.key_stored);
                    faults++;
                end
                if (got.pending_count !== want.pending_count)
                begin
                    $error("pending_count: expected %0d, got %0d",
                           want.pending_count, got.pending_count);
                    faults++;
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 beat_drv     = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  is_echo;
    logic                  key_stored;
    logic [CNT_W-1:0]      pending_count;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    echo_scoreboard sb = new();

    // Tick count that well-formed traffic stamps on its beats. It starts just
    // short of the wrap so that the first keys straddle it.
    logic [NOW_W-1:0]    ticks       = 32'hFFFF_FFF0;
    logic [EXPIRE_W-1:0] expire_now  = EXPIRE_RESET;
    logic [CONS_W-1:0]   session_cons = 6'd1;
    int                  burst_left  = 0;
    int                  items_sent  = 0;
    stall_mode_t         stall_mode  = STALL_NONE;
    logic [6:0]          stall_phase = '0;

    keystroke_echo_matcher_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (beat_drv.operation),
        .character     (beat_drv.character),
        .is_keysym     (beat_drv.is_keysym),
        .key_down      (beat_drv.key_down),
        .modifiers     (beat_drv.modifiers),
        .console_id    (beat_drv.console_id),
        .now           (beat_drv.now),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .is_echo       (is_echo),
        .key_stored    (key_stored),
        .pending_count (pending_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are observed on the rising edge, before any of that edge's
    // nonblocking updates land, so the values seen are the ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.take_item(beat_drv);
            if (result_valid && !result_stall)
                sb.check_result('{is_echo, key_stored, pending_count});
        end
    end

    // The result side draws a new stall pattern each time the 7-bit phase counter
    // wraps, so there are long stretches with no back-pressure as well as heavy ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_phase  <= '0;
            stall_mode   <= STALL_NONE;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == '0)
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     result_stall <= 1'b0;
                STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: result_stall <= stall_phase[2];
                default:        result_stall <= 1'b0;
            endcase
        end
    end

    // Ends the run if no beat moves on any port for too long.
    initial
    begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (item_valid && !item_stall) ||
                (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Moves the tick count on. Most steps stay well inside the expiry window;
    // some land exactly on its edge and some jump past it.
    function automatic void advance();
        int               pick;
        logic [NOW_W-1:0] step;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            step = NOW_W'(expire_now) + NOW_W'($urandom_range(1, 1000));
        else if (pick == 1)
            step = NOW_W'(expire_now);
        else
            step = NOW_W'($urandom_range(0, expire_now / 16 + 1));
        ticks = ticks + step;
    endfunction

    function automatic item_t keystroke(input logic [KEY_W-1:0] ch,
                                        input logic [CONS_W-1:0] cons,
                                        input logic [MOD_W-1:0] mods,
                                        input logic sym,
                                        input logic down);
        item_t it;
        it.operation  = OP_KEY;
        it.character  = ch;
        it.is_keysym  = sym;
        it.key_down   = down;
        it.modifiers  = mods;
        it.console_id = cons;
        it.now        = ticks;
        return it;
    endfunction

    // A character on screen. The key-only fields mean nothing here, so they
    // carry random values.
    function automatic item_t shown(input logic [KEY_W-1:0] ch);
        item_t it;
        it.operation  = OP_DISPLAY;
        it.character  = ch;
        it.is_keysym  = 1'($urandom);
        it.key_down   = 1'($urandom);
        it.modifiers  = MOD_W'($urandom);
        it.console_id = CONS_W'($urandom_range(1, 63));
        it.now        = ticks;
        return it;
    endfunction

    // Sends one input beat. Between bursts the valid line drops for a random
    // gap; a gap of zero keeps it high so that bursts run together.
    task automatic send_beat(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item_valid <= 1'b1;
        beat_drv   <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result beat has arrived,
    // then a little longer so that a surplus beat would still be seen. It waits
    // on the clock first so that the last accepted beat has reached the model.
    task automatic drain();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (!sb.drained())
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Writes the expiry register, then reads it back.
    task automatic cfg_write(input logic [EXPIRE_W-1:0] value);
        logic [APB_DATA_W-1:0] seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_EXPIRE, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== APB_DATA_W'(value))
        begin
            $error("expire_ticks readback: expected %0d, got %0d", value, seen);
            sb.faults++;
        end
        expire_now = value;
        sb.set_expire(value);
    endtask

    // One typing session: a run of keystrokes, mostly well formed with a few
    // rejected or random beats among them, followed by the characters that
    // the console shows back. Most of those echo the keys in order; some keys
    // are skipped and some characters are unrelated, which empties the store.
    task automatic run_session();
        logic [KEY_W-1:0] typed [$];
        logic [KEY_W-1:0] ch;
        logic [MOD_W-1:0] mods;
        item_t            it;
        int               n_keys;
        int               pick;
        if ($urandom_range(0, 4) == 0)
            session_cons = CONS_W'($urandom_range(1, 63));
        // Now and then the run is long enough to overflow the store.
        n_keys = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
        for (int i = 0; i < n_keys; i++)
        begin
            advance();
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                it.operation  = 1'($urandom);
                it.character  = KEY_W'($urandom);
                it.is_keysym  = 1'($urandom);
                it.key_down   = 1'($urandom);
                it.modifiers  = MOD_W'($urandom);
                it.console_id = CONS_W'($urandom_range(1, 63));
                it.now        = NOW_W'($urandom);
                send_beat(it);
            end
            else if (pick < 16)
            begin
                ch   = KEY_W'($urandom_range(1, 255));
                mods = MOD_W'($urandom) & ~REJECT_MODS;
                it   = keystroke(ch, CONS_W'($urandom_range(1, 63)), mods, 1'b1, 1'b1);
                case ($urandom_range(0, 3))
                    0:       it.character = '0;
                    1:       it.key_down  = 1'b0;
                    2:       it.is_keysym = 1'b0;
                    default: it.modifiers = mods | (MOD_W'(2) << $urandom_range(0, 2));
                endcase
                send_beat(it);
            end
            else
            begin
                ch = KEY_W'($urandom_range(1, 255));
                send_beat(keystroke(ch, session_cons, MOD_W'($urandom) & ~REJECT_MODS,
                                    1'b1, 1'b1));
                typed.push_back(ch);
            end
        end
        foreach (typed[i])
        begin
            advance();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_beat(shown(typed[i]));
            else if (pick >= 85)
                send_beat(shown(KEY_W'($urandom)));
        end
        if ($urandom_range(0, 9) == 0)
            send_beat(shown(KEY_W'($urandom)));
    endtask

    initial
    begin
        int start;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the expiry left at its reset value.
        // A shown character against an empty store changes nothing.
        send_beat(shown(8'h41));
        send_beat(shown(8'h00));
        // Console zero matches the console remembered after reset.
        send_beat(keystroke(8'h61, 6'd0, 8'h00, 1'b1, 1'b1));
        // A new console empties the store before the key goes in.
        send_beat(keystroke(8'h62, 6'd1, 8'h00, 1'b1, 1'b1));
        // Each filter in turn; rejected keys leave the console alone too.
        send_beat(keystroke(8'h00, 6'd1, 8'h00, 1'b1, 1'b1));
        send_beat(keystroke(8'h63, 6'd1, 8'h00, 1'b1, 1'b0));
        send_beat(keystroke(8'h63, 6'd1, 8'h00, 1'b0, 1'b1));
        send_beat(keystroke(8'h63, 6'd2, 8'h02, 1'b1, 1'b1));
        send_beat(keystroke(8'h63, 6'd62, 8'h04, 1'b1, 1'b1));
        send_beat(keystroke(8'h63, 6'd63, 8'h08, 1'b1, 1'b1));
        // Modifier bits outside the control and alt group are harmless.
        send_beat(keystroke(8'hFF, 6'd1, 8'hF1, 1'b1, 1'b1));
        // The tick count wraps before the echo arrives.
        ticks = ticks + 32'h20;
        send_beat(shown(8'h62));
        // Age exactly equal to the expiry still counts.
        ticks = 32'hFFFF_FFF0 + NOW_W'(EXPIRE_RESET);
        send_beat(shown(8'hFF));
        // A character that matches nothing empties the store.
        ticks = ticks + 32'd1000;
        send_beat(keystroke(8'h79, 6'd63, 8'h00, 1'b1, 1'b1));
        send_beat(shown(8'h71));
        // One tick past the expiry and the key no longer counts.
        send_beat(keystroke(8'h79, 6'd63, 8'h00, 1'b1, 1'b1));
        ticks = ticks + NOW_W'(EXPIRE_RESET) + 32'd1;
        send_beat(shown(8'h79));
        // A match in the middle drops that key and everything older.
        send_beat(keystroke(8'h70, 6'd63, 8'h00, 1'b1, 1'b1));
        send_beat(keystroke(8'h71, 6'd63, 8'h00, 1'b1, 1'b1));
        send_beat(keystroke(8'h72, 6'd63, 8'h00, 1'b1, 1'b1));
        send_beat(shown(8'h71));
        send_beat(shown(8'h72));
        drain();

        // Random phases, each under its own expiry setting, the extremes
        // included. The register is only touched once the block is idle.
        for (int k = 0; k < 5; k++)
        begin
            case (k)
                0:       cfg_write(16'd0);
                1:       cfg_write(16'hFFFF);
                2:       cfg_write(EXPIRE_RESET);
                3:       cfg_write(16'd3);
                default: cfg_write(EXPIRE_W'($urandom_range(1, 65534)));
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_BEATS)
                run_session();
            drain();
        end

        if (sb.faults == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> keystroke_echo_matcher_top.f
design/kem_pkg.sv
design/kem_ram.sv
design/kem_engine.sv
design/keystroke_echo_matcher_top.sv
tb/tb_keystroke_echo_matcher_top.sv
